// ===== rtl/rif_pkg.sv =====
// ----------------------------------------------------------------------------
// Region interval filter package
// Shared sizes, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rif_pkg;

  localparam int CHROM_COUNT   = 64;
  localparam int MAX_INTERVALS = 16;
  localparam int MAP_BITS      = 16;

  localparam int OP_W    = 2;
  localparam int CHROM_W = 6;
  localparam int POS_W   = 32;

  localparam int CPTR_W     = (CHROM_COUNT > 1) ? $clog2(CHROM_COUNT) : 1;
  localparam int CNT_W      = $clog2(MAX_INTERVALS + 1);
  localparam int SLOT_DEPTH = CHROM_COUNT * MAX_INTERVALS;
  localparam int ADDR_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  localparam int IN_FIELDS_W  = CHROM_W + 1 + 2 * POS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + MAP_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;

  typedef struct packed {
    logic load;
    logic decide;
    logic scan_issue;
    logic chrom_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            all_chroms;
    logic            direct;
    logic            cnt_zero;
    logic            last_chrom;
    logic            scan_last;
    logic            out_free;
  } sts_t;

endpackage

// ===== rtl/rif_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rif_datapath.sv =====
// ----------------------------------------------------------------------------
// Region interval filter datapath
// Request registers, interval and count memories, scan compare and result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rif_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rif_pkg::OP_W-1:0]        op_i,
  input  logic [rif_pkg::CHROM_W-1:0]     chrom_i,
  input  logic                            all_chroms_i,
  input  logic [rif_pkg::POS_W-1:0]       pos_low_i,
  input  logic [rif_pkg::POS_W-1:0]       pos_high_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_data_i,
  input  rif_pkg::cmd_t                   cmd_i,
  output rif_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            status_o,
  output logic                            hit_o,
  output logic [rif_pkg::MAP_BITS-1:0]    hit_map_o
);

  logic [rif_pkg::OP_W-1:0]      op_q, op_d;
  logic                          all_q, all_d;
  logic                          chrom_ok_q, chrom_ok_d;
  logic [rif_pkg::POS_W-1:0]     lo_q, lo_d;
  logic [rif_pkg::POS_W-1:0]     hi_q, hi_d;
  logic [rif_pkg::CPTR_W-1:0]    c_q, c_d;
  logic [rif_pkg::CNT_W-1:0]     n_q, n_d;
  logic [rif_pkg::CNT_W-1:0]     i_q, i_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic [rif_pkg::CNT_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                          status_q, status_d;
  logic                          hit_q, hit_d;
  logic [rif_pkg::MAP_BITS-1:0]  map_q, map_d;
  logic                          en_q, en_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_status_q;
  logic                          out_hit_q;
  logic [rif_pkg::MAP_BITS-1:0]  out_map_q;
  logic [rif_pkg::CHROM_COUNT-1:0] cnt_valid_q, cnt_valid_d;

  logic [rif_pkg::CNT_W-1:0]     cnt_rdata;
  logic [rif_pkg::CNT_W-1:0]     cur_cnt;
  logic                          full;
  logic                          ins_we;
  logic [rif_pkg::ADDR_W-1:0]    slot_base;
  logic [rif_pkg::ADDR_W-1:0]    wr_addr;
  logic [rif_pkg::ADDR_W-1:0]    rd_addr;
  logic [2*rif_pkg::POS_W-1:0]   slot_rdata;
  logic [rif_pkg::POS_W-1:0]     slot_start;
  logic [rif_pkg::POS_W-1:0]     slot_end;
  logic                          match;

  assign cur_cnt    = cnt_valid_q[c_q] ? cnt_rdata : '0;
  assign full       = cur_cnt >= rif_pkg::CNT_W'(rif_pkg::MAX_INTERVALS);
  assign ins_we     = cmd_i.decide && (op_q == rif_pkg::OP_INSERT) && !full;
  assign slot_base  = rif_pkg::ADDR_W'(c_q) * rif_pkg::ADDR_W'(rif_pkg::MAX_INTERVALS);
  assign wr_addr    = slot_base + rif_pkg::ADDR_W'(cur_cnt);
  assign rd_addr    = slot_base + rif_pkg::ADDR_W'(i_q);
  assign slot_start = slot_rdata[rif_pkg::POS_W-1:0];
  assign slot_end   = slot_rdata[2*rif_pkg::POS_W-1:rif_pkg::POS_W];

  rif_ram #(
    .WIDTH (rif_pkg::CNT_W),
    .DEPTH (rif_pkg::CHROM_COUNT)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (c_q),
    .wdata_i (cur_cnt + rif_pkg::CNT_W'(1)),
    .raddr_i (c_q),
    .rdata_o (cnt_rdata)
  );

  rif_ram #(
    .WIDTH (2 * rif_pkg::POS_W),
    .DEPTH (rif_pkg::SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (wr_addr),
    .wdata_i ({hi_q, lo_q}),
    .raddr_i (rd_addr),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    if (op_q == rif_pkg::OP_SITE) begin
      match = (lo_q >= slot_start) && (lo_q <= slot_end);
    end else begin
      match = (slot_start <= hi_q) && (slot_end >= lo_q);
    end
  end

  always_comb begin
    op_d        = op_q;
    all_d       = all_q;
    chrom_ok_d  = chrom_ok_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    c_d         = c_q;
    n_d         = n_q;
    i_d         = i_q;
    cmp_vld_d   = cmd_i.scan_issue;
    cmp_idx_d   = i_q;
    status_d    = status_q;
    hit_d       = hit_q;
    map_d       = map_q;
    en_d        = cfg_we_i ? cfg_data_i : en_q;
    cnt_valid_d = cnt_valid_q;
    out_valid_d = out_valid_q;

    if (cmd_i.load) begin
      op_d       = op_i;
      all_d      = all_chroms_i;
      chrom_ok_d = {{(32-rif_pkg::CHROM_W){1'b0}}, chrom_i} < 32'(rif_pkg::CHROM_COUNT);
      lo_d       = pos_low_i;
      hi_d       = pos_high_i;
      c_d        = (all_chroms_i && (op_i == rif_pkg::OP_INSERT)) ? '0 :
                   rif_pkg::CPTR_W'(chrom_i);
      status_d   = 1'b0;
      hit_d      = (op_i == rif_pkg::OP_RANGE) && !en_q;
      map_d      = '0;
    end

    if (cmd_i.decide) begin
      if (op_q == rif_pkg::OP_INSERT) begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          cnt_valid_d[c_q] = 1'b1;
        end
      end else begin
        n_d = cur_cnt;
        i_d = '0;
      end
    end

    if (cmd_i.chrom_next) begin
      c_d = c_q + rif_pkg::CPTR_W'(1);
    end

    if (cmd_i.scan_issue) begin
      i_d = i_q + rif_pkg::CNT_W'(1);
    end

    if (cmp_vld_q && match) begin
      hit_d = 1'b1;
      if (op_q == rif_pkg::OP_RANGE) begin
        for (int b = 0; b < rif_pkg::MAP_BITS; b++) begin
          if (32'(cmp_idx_q) == b) begin
            map_d[b] = 1'b1;
          end
        end
      end
    end

    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q   <= 1'b0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
    end else begin
      cmp_vld_q   <= cmp_vld_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
      cnt_valid_q <= cnt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    all_q      <= all_d;
    chrom_ok_q <= chrom_ok_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    c_q        <= c_d;
    n_q        <= n_d;
    i_q        <= i_d;
    cmp_idx_q  <= cmp_idx_d;
    status_q   <= status_d;
    hit_q      <= hit_d;
    map_q      <= map_d;
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_hit_q    <= hit_q;
      out_map_q    <= map_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.all_chroms = all_q;
  assign sts_o.direct     = (op_q != rif_pkg::OP_INSERT && op_q != rif_pkg::OP_SITE &&
                             op_q != rif_pkg::OP_RANGE) ||
                            (op_q == rif_pkg::OP_RANGE && !en_q) ||
                            (!chrom_ok_q && !(op_q == rif_pkg::OP_INSERT && all_q));
  assign sts_o.cnt_zero   = cur_cnt == '0;
  assign sts_o.last_chrom = c_q == rif_pkg::CPTR_W'(rif_pkg::CHROM_COUNT - 1);
  assign sts_o.scan_last  = i_q == (n_q - rif_pkg::CNT_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hit_o       = out_hit_q;
  assign hit_map_o   = out_map_q;

endmodule

// ===== rtl/rif_ctrl.sv =====
// ----------------------------------------------------------------------------
// Region interval filter controller
// Sequences count lookup, insert commit, interval scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rif_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rif_pkg::sts_t sts_i,
  output rif_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CREAD  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CREAD;
        end
      end
      S_CREAD: begin
        state_d = sts_i.direct ? S_DONE : S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.op == rif_pkg::OP_INSERT) begin
          if (sts_i.all_chroms && !sts_i.last_chrom) begin
            cmd_o.chrom_next = 1'b1;
            state_d          = S_CREAD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = sts_i.cnt_zero ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_issue && sts_i.scan_last) |=> !cmd_o.scan_issue)
    else $error("scan continued past last interval");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.decide && cmd_o.scan_issue))
    else $error("insert commit overlaps interval scan");

endmodule

// ===== rtl/region_interval_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Region interval filter unit
// Per-chromosome tables of inclusive intervals with insert, site and range
// queries.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A single-chromosome
// insert reads the chromosome's count and then commits, an all-chromosome insert
// does one count read and one commit per chromosome, and a query reads the count
// and then scans the chromosome's intervals through the interval memory read
// port, which delivers one stored interval per cycle. Requests that need no
// table access (unused op, range query with filtering off, chromosome out of
// range) skip the commit and the scan. A new request is taken in the cycle
// after the result is loaded into the output register.
`timescale 1ns / 1ps

module region_interval_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] chrom, [6] all_chroms, [38:7] pos_low, [70:39] pos_high, [71] zero
  input  logic [rif_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] op
  input  logic [rif_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] status, [1] hit, [17:2] hit_map, [23:18] zero
  output logic [rif_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i
);

  rif_pkg::cmd_t                cmd;
  rif_pkg::sts_t                sts;
  logic                         status;
  logic                         hit;
  logic [rif_pkg::MAP_BITS-1:0] hit_map;

  assign cfg_ready_o = 1'b1;

  rif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rif_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (s_axis_tuser),
    .chrom_i      (s_axis_tdata[rif_pkg::CHROM_W-1:0]),
    .all_chroms_i (s_axis_tdata[rif_pkg::CHROM_W]),
    .pos_low_i    (s_axis_tdata[rif_pkg::CHROM_W+rif_pkg::POS_W:rif_pkg::CHROM_W+1]),
    .pos_high_i   (s_axis_tdata[rif_pkg::CHROM_W+2*rif_pkg::POS_W:
                                rif_pkg::CHROM_W+rif_pkg::POS_W+1]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_o     (status),
    .hit_o        (hit),
    .hit_map_o    (hit_map)
  );

  assign m_axis_tdata = {{(rif_pkg::OUT_DATA_W-rif_pkg::OUT_FIELDS_W){1'b0}},
                         hit_map, hit, status};

endmodule

// ===== tb/tb_region_interval_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Region interval filter unit testbench
// Drives insert, site query and range query requests over the input stream,
// predicts every result from a private copy of the interval tables and
// compares each returned result field by field, in order. Runs phases with
// and without filtering, with random gaps on the sender and random stalls on
// the receiver, plus one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_region_interval_filter_unit;
  import rif_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int PHASE_REQUESTS = 255;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * CHROM_COUNT + 8;

  typedef struct packed {
    logic                status;
    logic                hit;
    logic [MAP_BITS-1:0] hit_map;
  } filter_result_t;

  class interval_scoreboard;
    logic [POS_W-1:0] start_tab [CHROM_COUNT][MAX_INTERVALS];
    logic [POS_W-1:0] end_tab [CHROM_COUNT][MAX_INTERVALS];
    int unsigned      fill [CHROM_COUNT];
    logic             filter_en;
    filter_result_t   expected_results [$];
    int               errors;

    function new();
      foreach (fill[c]) fill[c] = 0;
      filter_en = 1'b0;
      errors = 0;
    endfunction

    function logic store_interval(int c, logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      if (fill[c] >= MAX_INTERVALS) return 1'b1;
      start_tab[c][fill[c]] = lo;
      end_tab[c][fill[c]] = hi;
      fill[c]++;
      return 1'b0;
    endfunction

    function filter_result_t evaluate_request(logic [OP_W-1:0] op, logic [CHROM_W-1:0] chrom,
                                              logic all, logic [POS_W-1:0] lo,
                                              logic [POS_W-1:0] hi);
      filter_result_t r;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (all) begin
            for (int c = 0; c < CHROM_COUNT; c++) r.status = r.status | store_interval(c, lo, hi);
          end else begin
            r.status = store_interval(chrom, lo, hi);
          end
        end
        OP_SITE: begin
          for (int i = 0; i < fill[chrom]; i++)
            if (lo >= start_tab[chrom][i] && lo <= end_tab[chrom][i]) r.hit = 1'b1;
        end
        OP_RANGE: begin
          if (!filter_en) begin
            r.hit = 1'b1;
          end else begin
            for (int i = 0; i < fill[chrom]; i++) begin
              if (start_tab[chrom][i] <= hi && end_tab[chrom][i] >= lo) begin
                r.hit = 1'b1;
                if (i < MAP_BITS) r.hit_map[i] = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [CHROM_W-1:0] chrom, logic all,
                               logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      expected_results.push_back(evaluate_request(op, chrom, all, lo, hi));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      filter_result_t got;
      filter_result_t want;
      got.status = data[0];
      got.hit = data[1];
      got.hit_map = data[2 +: MAP_BITS];
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pending request", 32'(got), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.hit_map !== want.hit_map)
          report_mismatch("hit_map", 32'(got.hit_map), 32'(want.hit_map));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [IN_DATA_W-1:0]  in_data = '0;
  logic [OP_W-1:0]       in_op = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_ready_o;

  interval_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;

  region_interval_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: check, then hold off or stall at random
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_axis_tvalid && out_ready) sb.check_result(m_axis_tdata);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles = hold_off_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHROM_W-1:0] chrom,
                              input logic all, input logic [POS_W-1:0] lo,
                              input logic [POS_W-1:0] hi);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, hi, lo, all, chrom};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, chrom, all, lo, hi);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_filter_enable(input logic value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    sb.filter_en = value;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return POS_W'($urandom_range(0, 4095));
    if (r < 60) return 32'hFFFF_FFFF - POS_W'($urandom_range(0, 4095));
    if (r < 70) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] span_from(logic [POS_W-1:0] lo);
    logic [POS_W-1:0] span;
    span = POS_W'($urandom_range(0, 300));
    if (lo > 32'hFFFF_FFFF - span) return 32'hFFFF_FFFF;
    return lo + span;
  endfunction

  task automatic send_random_request();
    logic [OP_W-1:0]    op;
    logic [CHROM_W-1:0] chrom;
    logic               all;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    int                 r;
    int                 n;
    int                 k;
    r = $urandom_range(0, 99);
    op = (r < 30) ? OP_INSERT : (r < 62) ? OP_SITE : (r < 95) ? OP_RANGE : OP_UNUSED;
    chrom = $urandom_range(0, 1) ? CHROM_W'($urandom_range(0, 7))
                                 : CHROM_W'($urandom_range(0, CHROM_COUNT - 1));
    all = (op == OP_INSERT) ? ($urandom_range(0, 99) < 3) : 1'($urandom_range(0, 1));
    lo = pick_position();
    n = sb.fill[chrom];
    // probe the edges of stored intervals
    if (op != OP_INSERT && n > 0 && $urandom_range(0, 99) < 60) begin
      k = $urandom_range(0, n - 1);
      lo = ($urandom_range(0, 1) ? sb.start_tab[chrom][k] : sb.end_tab[chrom][k])
           + POS_W'($urandom_range(0, 2)) - 32'd1;
    end
    hi = span_from(lo);
    if ($urandom_range(0, 99) < 10) hi = $urandom;
    send_request(op, chrom, all, lo, hi);
  endtask

  int idle_tab [4] = '{0, 79, 0, 27};
  int stall_tab [4] = '{0, 0, 79, 27};
  logic enable_tab [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // filtering off after reset
    send_request(OP_RANGE, 6'd0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_SITE, 6'd5, 1'b0, 32'h0, 32'h0);
    send_request(OP_UNUSED, 6'd63, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 6'd0, 1'b0, 32'h0, 32'h0);
    send_request(OP_INSERT, 6'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 6'd63, 1'b0, 32'd100, 32'd200);
    send_request(OP_INSERT, 6'd63, 1'b0, 32'd300, 32'd250);
    send_request(OP_SITE, 6'd63, 1'b0, 32'd250, 32'd0);
    send_request(OP_SITE, 6'd63, 1'b0, 32'd100, 32'd0);
    send_request(OP_SITE, 6'd0, 1'b0, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_RANGE, 6'd63, 1'b0, 32'h0, 32'hFFFF_FFFF);

    write_filter_enable(1'b1);
    send_request(OP_RANGE, 6'd63, 1'b0, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_RANGE, 6'd63, 1'b0, 32'd400, 32'd120);
    send_request(OP_RANGE, 6'd0, 1'b0, 32'd1, 32'hFFFF_FFFE);
    send_request(OP_INSERT, 6'd0, 1'b1, 32'd1000, 32'd2000);
    // fill one list, then overflow it alone and with every chromosome
    for (int i = 0; i < MAX_INTERVALS - 1; i++)
      send_request(OP_INSERT, 6'd9, 1'b0, 32'(i * 10), 32'(i * 10 + 5));
    send_request(OP_INSERT, 6'd9, 1'b0, 32'd5, 32'd5);
    send_request(OP_INSERT, 6'd0, 1'b1, 32'd3000, 32'd3000);
    send_request(OP_RANGE, 6'd9, 1'b0, 32'h0, 32'hFFFF_FFFF);

    for (int p = 0; p < 4; p++) begin
      write_filter_enable(enable_tab[p]);
      sender_idle_pct = idle_tab[p];
      receiver_stall_pct = stall_tab[p];
      if (p == 0) hold_off_cycles = HOLD_OFF_CYCLES;
      repeat (PHASE_REQUESTS) send_random_request();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
